/* rtl/core/segment_box_slab_test_defines.svh */
// Assertion macros for the segment/box slab test.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SEGMENT_BOX_SLAB_TEST_DEFINES_SVH
`define SEGMENT_BOX_SLAB_TEST_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SBST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment_box_slab_test: implication check failed");

// Next-cycle implication, disabled while in reset
`define SBST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment_box_slab_test: next-cycle check failed");

`endif

/* rtl/core/sbst_pkg.sv */
package sbst_pkg;

  // Coordinate width (signed Q16.16 at the default)
  localparam int COORD_BITS = 32;
  localparam int AXES       = 3;
  // Differences of two coordinates need one more bit
  localparam int NUM_W      = COORD_BITS + 1;
  // Signed numerator times positive denominator, with headroom
  localparam int PROD_W     = 2 * NUM_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [NUM_W-1:0]      num_t;
  typedef logic        [COORD_BITS-1:0] den_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  // Per-item working set carried down the clipping pipeline
  typedef struct packed {
    logic                ok;
    logic [AXES-1:0]     zero;
    num_t [AXES-1:0]     en;
    num_t [AXES-1:0]     xn;
    den_t [AXES-1:0]     den;
    num_t                tmin_n;
    den_t                tmin_d;
    num_t                tmax_n;
    den_t                tmax_d;
  } slab_t;

  // Cross products for one axis step
  typedef struct packed {
    prod_t p_en;
    prod_t q_en;
    prod_t p_x;
    prod_t q_x;
  } xprod_t;

  // Final interval check
  typedef struct packed {
    logic  ok;
    prod_t lhs;
    prod_t rhs;
  } fin_t;

  // Exact product of a signed numerator and a positive denominator
  function automatic prod_t mul_nd(num_t n, den_t d);
    prod_t a;
    prod_t b;
    a = {{(PROD_W-NUM_W){n[NUM_W-1]}}, n};
    b = {{(PROD_W-COORD_BITS){1'b0}}, d};
    return prod_t'(a * b);
  endfunction

endpackage

/* rtl/core/segment_box_slab_test.sv */
// Segment versus axis-aligned box test by slab clipping, exact fractions.
// The result strobe is registered after the setup, per-axis multiply and compare, and final-product registers.
// Throughput: one item per cycle; busy is held low, nothing stalls.
// Stages: slab setup, then multiply/compare per axis, then final check.
// Reset (rst_n low, synchronous) clears every valid bit; data is not reset.
`include "segment_box_slab_test_defines.svh"

module segment_box_slab_test (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  sbst_pkg::coord_t     in_seg_start_x,
  input  sbst_pkg::coord_t     in_seg_start_y,
  input  sbst_pkg::coord_t     in_seg_start_z,
  input  sbst_pkg::coord_t     in_seg_end_x,
  input  sbst_pkg::coord_t     in_seg_end_y,
  input  sbst_pkg::coord_t     in_seg_end_z,
  input  sbst_pkg::coord_t     in_box_low_x,
  input  sbst_pkg::coord_t     in_box_low_y,
  input  sbst_pkg::coord_t     in_box_low_z,
  input  sbst_pkg::coord_t     in_box_high_x,
  input  sbst_pkg::coord_t     in_box_high_y,
  input  sbst_pkg::coord_t     in_box_high_z,
  output logic                 out_valid,
  output logic                 out_hit
);

  localparam int AXES = sbst_pkg::AXES;
  localparam int W    = sbst_pkg::COORD_BITS;
  localparam int NW   = sbst_pkg::NUM_W;

  logic accept;

  sbst_pkg::coord_t s_ax [AXES];
  sbst_pkg::coord_t e_ax [AXES];
  sbst_pkg::coord_t l_ax [AXES];
  sbst_pkg::coord_t h_ax [AXES];

  sbst_pkg::slab_t  s1_nxt;
  sbst_pkg::slab_t  s1_r;
  logic             s1_vld_r;

  sbst_pkg::slab_t  mul_in   [AXES];
  sbst_pkg::slab_t  mul_r    [AXES];
  logic             mul_vld_in [AXES];
  logic             mul_vld_r  [AXES];
  sbst_pkg::xprod_t xp_r     [AXES];
  sbst_pkg::slab_t  cmp_nxt  [AXES];
  sbst_pkg::slab_t  cmp_r    [AXES];
  logic             cmp_vld_r  [AXES];

  sbst_pkg::fin_t   fin_r;
  logic             fin_vld_r;
  logic             out_valid_r;
  logic             out_hit_r;

  function automatic sbst_pkg::den_t den_t_one();
    return sbst_pkg::den_t'(1);
  endfunction

  // Never stalls: the receiver takes every result
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign s_ax = '{in_seg_start_x, in_seg_start_y, in_seg_start_z};
  assign e_ax = '{in_seg_end_x,   in_seg_end_y,   in_seg_end_z};
  assign l_ax = '{in_box_low_x,   in_box_low_y,   in_box_low_z};
  assign h_ax = '{in_box_high_x,  in_box_high_y,  in_box_high_z};

  // Slab setup: ordered corners, direction, entry/exit numerators
  always_comb begin
    sbst_pkg::coord_t lo;
    sbst_pkg::coord_t hi;
    sbst_pkg::num_t   d;
    sbst_pkg::num_t   dl;
    sbst_pkg::num_t   dh;
    sbst_pkg::num_t   dneg;
    s1_nxt        = '0;
    s1_nxt.ok     = 1'b1;
    s1_nxt.tmin_n = '0;
    s1_nxt.tmin_d = den_t_one();
    s1_nxt.tmax_n = sbst_pkg::num_t'(1);
    s1_nxt.tmax_d = den_t_one();
    for (int a = 0; a < AXES; a++) begin
      if (h_ax[a] < l_ax[a]) begin
        lo = h_ax[a];
        hi = l_ax[a];
      end else begin
        lo = l_ax[a];
        hi = h_ax[a];
      end
      d    = {e_ax[a][W-1], e_ax[a]} - {s_ax[a][W-1], s_ax[a]};
      dl   = {lo[W-1], lo} - {s_ax[a][W-1], s_ax[a]};
      dh   = {hi[W-1], hi} - {s_ax[a][W-1], s_ax[a]};
      dneg = -d;
      s1_nxt.zero[a] = (d == '0);
      if (d == '0) begin
        // parallel to this slab: start must lie inside it
        if (dl > 0 || dh < 0) s1_nxt.ok = 1'b0;
        s1_nxt.en[a]  = dl;
        s1_nxt.xn[a]  = dh;
        s1_nxt.den[a] = den_t_one();
      end else if (d[NW-1]) begin
        s1_nxt.en[a]  = -dh;
        s1_nxt.xn[a]  = -dl;
        s1_nxt.den[a] = dneg[W-1:0];
      end else begin
        s1_nxt.en[a]  = dl;
        s1_nxt.xn[a]  = dh;
        s1_nxt.den[a] = d[W-1:0];
      end
    end
  end

  // Setup register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    s1_r <= s1_nxt;
  end

  // One multiply stage and one compare stage per axis
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    if (a == 0) begin : g_first
      assign mul_in[a]     = s1_r;
      assign mul_vld_in[a] = s1_vld_r;
    end else begin : g_next
      assign mul_in[a]     = cmp_r[a-1];
      assign mul_vld_in[a] = cmp_vld_r[a-1];
    end

    // Cross products against the current interval
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mul_vld_r[a] <= 1'b0;
      end else begin
        mul_vld_r[a] <= mul_vld_in[a];
      end
      mul_r[a]     <= mul_in[a];
      xp_r[a].p_en <= sbst_pkg::mul_nd(mul_in[a].en[a], mul_in[a].tmin_d);
      xp_r[a].q_en <= sbst_pkg::mul_nd(mul_in[a].tmin_n, mul_in[a].den[a]);
      xp_r[a].p_x  <= sbst_pkg::mul_nd(mul_in[a].tmax_n, mul_in[a].den[a]);
      xp_r[a].q_x  <= sbst_pkg::mul_nd(mul_in[a].xn[a], mul_in[a].tmax_d);
    end

    // Narrow the interval when this axis is tighter
    always_comb begin
      cmp_nxt[a] = mul_r[a];
      if (!mul_r[a].zero[a] && (xp_r[a].p_en > xp_r[a].q_en)) begin
        cmp_nxt[a].tmin_n = mul_r[a].en[a];
        cmp_nxt[a].tmin_d = mul_r[a].den[a];
      end
      if (!mul_r[a].zero[a] && (xp_r[a].p_x > xp_r[a].q_x)) begin
        cmp_nxt[a].tmax_n = mul_r[a].xn[a];
        cmp_nxt[a].tmax_d = mul_r[a].den[a];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cmp_vld_r[a] <= 1'b0;
      end else begin
        cmp_vld_r[a] <= mul_vld_r[a];
      end
      cmp_r[a] <= cmp_nxt[a];
    end
  end

  // Final products: tmin versus tmax
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= cmp_vld_r[AXES-1];
    end
    fin_r.ok  <= cmp_r[AXES-1].ok;
    fin_r.lhs <= sbst_pkg::mul_nd(cmp_r[AXES-1].tmin_n, cmp_r[AXES-1].tmax_d);
    fin_r.rhs <= sbst_pkg::mul_nd(cmp_r[AXES-1].tmax_n, cmp_r[AXES-1].tmin_d);
  end

  // Result beat: hit unless a parallel slab missed or the interval is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_vld_r;
    end
    out_hit_r <= fin_r.ok && !(fin_r.lhs > fin_r.rhs);
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // Checks
  `SBST_ASSERT_IMP(a_strobe_after_accept, out_valid, $past(accept, 9))
  `SBST_ASSERT_NXT(a_slab_miss_reported, fin_vld_r && !fin_r.ok, !out_hit)
  `SBST_ASSERT_IMP(a_point_keeps_unit_interval,
    cmp_vld_r[AXES-1] && (&cmp_r[AXES-1].zero),
    (cmp_r[AXES-1].tmin_n == '0) && (cmp_r[AXES-1].tmax_n == sbst_pkg::num_t'(1)))

endmodule

/* dv/segment_box_slab_test_chk.sv */
module segment_box_slab_test_chk (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  sbst_pkg::coord_t in_seg_start_x,
  input  sbst_pkg::coord_t in_seg_start_y,
  input  sbst_pkg::coord_t in_seg_start_z,
  input  sbst_pkg::coord_t in_seg_end_x,
  input  sbst_pkg::coord_t in_seg_end_y,
  input  sbst_pkg::coord_t in_seg_end_z,
  input  sbst_pkg::coord_t in_box_low_x,
  input  sbst_pkg::coord_t in_box_low_y,
  input  sbst_pkg::coord_t in_box_low_z,
  input  sbst_pkg::coord_t in_box_high_x,
  input  sbst_pkg::coord_t in_box_high_y,
  input  sbst_pkg::coord_t in_box_high_z,
  input  logic             out_valid,
  input  logic             out_hit,
  output int               errors,
  output int               pending,
  output int               checked,
  output int               hits
);
  timeunit 1ns;
  timeprecision 1ps;

  // index 0..2 start xyz, 3..5 end xyz, 6..8 low corner, 9..11 high corner
  typedef sbst_pkg::coord_t [11:0] pair_t;
  typedef logic signed [79:0] cross_t;

  bit hit_q[$];
  bit want;

  // an/ad > bn/bd for positive denominators, by exact cross multiplication
  function automatic bit frac_above(longint an, longint ad, longint bn, longint bd);
    cross_t lhs;
    cross_t rhs;
    lhs = cross_t'(an) * cross_t'(bd);
    rhs = cross_t'(bn) * cross_t'(ad);
    return lhs > rhs;
  endfunction

  // Slab clipping over t in [0,1], boundaries count as touching
  function automatic bit predict_hit(pair_t p);
    longint enter_n, enter_d, leave_n, leave_d;
    longint s, e, lo, hi, d, en, xn, den, tmp;
    bit     hit_ok;
    int     ax;
    enter_n = 0;
    enter_d = 1;
    leave_n = 1;
    leave_d = 1;
    hit_ok  = 1'b1;
    for (ax = 0; ax < 3; ax++) begin
      s  = longint'($signed(p[ax]));
      e  = longint'($signed(p[3+ax]));
      lo = longint'($signed(p[6+ax]));
      hi = longint'($signed(p[9+ax]));
      // swapped corners are put back in order
      if (hi < lo) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      d = e - s;
      if (d == 0) begin
        // flat on this axis: start must sit inside the slab
        if (lo > s || hi < s) hit_ok = 1'b0;
      end else begin
        if (d > 0) begin
          en  = lo - s;
          xn  = hi - s;
          den = d;
        end else begin
          en  = s - hi;
          xn  = s - lo;
          den = -d;
        end
        if (frac_above(en, den, enter_n, enter_d)) begin
          enter_n = en;
          enter_d = den;
        end
        if (frac_above(leave_n, leave_d, xn, den)) begin
          leave_n = xn;
          leave_d = den;
        end
      end
    end
    if (frac_above(enter_n, enter_d, leave_n, leave_d)) hit_ok = 1'b0;
    return hit_ok;
  endfunction

  task automatic report(string msg);
    $display("%0t ns chk: %s", $time, msg);
    errors++;
  endtask

  // Predict on accepted beats, compare on result strobes
  always @(posedge clk) begin
    if (!rst_n) begin
      hit_q.delete();
      pending <= 0;
    end else begin
      if (start && !busy)
        hit_q.push_back(predict_hit({in_box_high_z, in_box_high_y, in_box_high_x,
                                     in_box_low_z, in_box_low_y, in_box_low_x,
                                     in_seg_end_z, in_seg_end_y, in_seg_end_x,
                                     in_seg_start_z, in_seg_start_y, in_seg_start_x}));
      if (out_valid) begin
        if (hit_q.size() == 0) begin
          report($sformatf("result with no beat outstanding (hit=%0b)", out_hit));
        end else begin
          want = hit_q.pop_front();
          checked++;
          if (out_hit === 1'b1) hits++;
          if (out_hit !== want)
            report($sformatf("result %0d: hit=%0b, want %0b", checked, out_hit, want));
        end
      end
      pending <= hit_q.size();
    end
  end

endmodule

/* dv/segment_box_slab_test_tb.sv */
module segment_box_slab_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef sbst_pkg::coord_t coord_t;
  typedef coord_t [11:0] pair_t;
  typedef enum int {K_NOISE, K_WELL, K_FLAT, K_POINT, K_TOUCH, K_EXTREME} pair_kind_t;

  localparam int ONE          = 1 << 16;
  localparam int CMIN         = int'(32'h8000_0000);
  localparam int CMAX         = int'(32'h7fff_ffff);
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 24;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  logic  out_valid;
  logic  out_hit;
  pair_t pair_drv;

  int errors;
  int pending;
  int checked;
  int hits;
  int cycles = 0;
  int sent = 0;
  int n_directed;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  segment_box_slab_test i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_seg_start_x (pair_drv[0]),
    .in_seg_start_y (pair_drv[1]),
    .in_seg_start_z (pair_drv[2]),
    .in_seg_end_x   (pair_drv[3]),
    .in_seg_end_y   (pair_drv[4]),
    .in_seg_end_z   (pair_drv[5]),
    .in_box_low_x   (pair_drv[6]),
    .in_box_low_y   (pair_drv[7]),
    .in_box_low_z   (pair_drv[8]),
    .in_box_high_x  (pair_drv[9]),
    .in_box_high_y  (pair_drv[10]),
    .in_box_high_z  (pair_drv[11]),
    .out_valid      (out_valid),
    .out_hit        (out_hit)
  );

  segment_box_slab_test_chk i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_seg_start_x (pair_drv[0]),
    .in_seg_start_y (pair_drv[1]),
    .in_seg_start_z (pair_drv[2]),
    .in_seg_end_x   (pair_drv[3]),
    .in_seg_end_y   (pair_drv[4]),
    .in_seg_end_z   (pair_drv[5]),
    .in_box_low_x   (pair_drv[6]),
    .in_box_low_y   (pair_drv[7]),
    .in_box_low_z   (pair_drv[8]),
    .in_box_high_x  (pair_drv[9]),
    .in_box_high_y  (pair_drv[10]),
    .in_box_high_z  (pair_drv[11]),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .errors         (errors),
    .pending        (pending),
    .checked        (checked),
    .hits           (hits)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic pair_t pair_of(int sx, int sy, int sz, int ex, int ey, int ez,
                                    int lx, int ly, int lz, int hx, int hy, int hz);
    return {coord_t'(hz), coord_t'(hy), coord_t'(hx), coord_t'(lz), coord_t'(ly),
            coord_t'(lx), coord_t'(ez), coord_t'(ey), coord_t'(ex), coord_t'(sz),
            coord_t'(sy), coord_t'(sx)};
  endfunction

  // Segment against the cube [0,2]^3
  function automatic pair_t seg_vs_cube(int sx, int sy, int sz, int ex, int ey, int ez);
    return pair_of(sx, sy, sz, ex, ey, ez, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE);
  endfunction

  function automatic coord_t extreme_val();
    case ($urandom_range(0, 5))
      0:       return coord_t'(CMIN);
      1:       return coord_t'(CMAX);
      2:       return '0;
      3:       return '1;
      4:       return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Random segment/box pair of the given flavor
  function automatic pair_t random_pair(pair_kind_t kind);
    pair_t p;
    int    sv[3], ev[3], lv[3], hv[3];
    int    ctr, half, k, j, a, ax, flat_ax, tmp;
    flat_ax = $urandom_range(0, 2);
    for (ax = 0; ax < 3; ax++) begin
      ctr    = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      half   = int'($urandom_range(0, 1 << 18));
      lv[ax] = ctr - half;
      hv[ax] = ctr + half + 1;
      sv[ax] = ctr + int'($urandom_range(0, 6 * half + 2)) - (3 * half + 1);
      ev[ax] = ctr + int'($urandom_range(0, 6 * half + 2)) - (3 * half + 1);
      if (kind == K_POINT ||
          (kind == K_FLAT && (ax == flat_ax || $urandom_range(0, 1) == 0))) begin
        ev[ax] = sv[ax];
      end else if (kind == K_TOUCH) begin
        sv[ax] = ctr;
        ev[ax] = ctr;
      end
    end
    if (kind == K_TOUCH) begin
      k = $urandom_range(0, 2);
      j = (k + 1) % 3;
      a = int'($urandom_range(1, 1 << 16));
      if ($urandom_range(0, 1) == 0) begin
        // one end lands exactly on the upper face
        sv[k] = hv[k] + a;
        ev[k] = hv[k];
      end else begin
        // grazes the upper edge of axes k and j, maybe off by one LSB
        sv[k] = hv[k] + a + int'($urandom_range(0, 2)) - 1;
        sv[j] = hv[j] - a;
        ev[k] = hv[k] - a;
        ev[j] = hv[j] + a;
      end
      if ($urandom_range(0, 1) == 0) begin
        for (ax = 0; ax < 3; ax++) begin
          tmp    = sv[ax];
          sv[ax] = ev[ax];
          ev[ax] = tmp;
        end
      end
    end
    for (ax = 0; ax < 3; ax++) begin
      p[ax]   = coord_t'(sv[ax]);
      p[3+ax] = coord_t'(ev[ax]);
      if (kind != K_TOUCH && $urandom_range(0, 9) == 0) begin
        p[6+ax] = coord_t'(hv[ax]);
        p[9+ax] = coord_t'(lv[ax]);
      end else begin
        p[6+ax] = coord_t'(lv[ax]);
        p[9+ax] = coord_t'(hv[ax]);
      end
    end
    for (ax = 0; ax < 12; ax++) begin
      if (kind == K_NOISE) p[ax] = coord_t'($urandom);
      else if (kind == K_EXTREME) p[ax] = extreme_val();
    end
    return p;
  endfunction

  // One beat; start stays high into the next beat when there is no gap
  task automatic send_pair(pair_t p, int gap);
    pair_drv <= p;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    pair_kind_t kind;
    bit         burst;
    int         n;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    pair_drv <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: points, faces, corners, flat axes, swapped corners, extremes
    send_pair(seg_vs_cube(ONE, ONE, ONE, ONE, ONE, ONE), $urandom_range(0, 17));
    send_pair(seg_vs_cube(2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE), 0);
    send_pair(seg_vs_cube(3 * ONE, ONE, ONE, 3 * ONE, ONE, ONE), $urandom_range(0, 17));
    send_pair(seg_vs_cube(-5 * ONE, ONE, ONE, 5 * ONE, ONE, ONE), 0);
    send_pair(seg_vs_cube(-5 * ONE, 3 * ONE, ONE, 5 * ONE, 3 * ONE, ONE), 0);
    send_pair(seg_vs_cube(3 * ONE, ONE, ONE, ONE, 3 * ONE, ONE), $urandom_range(0, 17));
    send_pair(seg_vs_cube(3 * ONE + 1, ONE, ONE, ONE, 3 * ONE, ONE), 0);
    send_pair(seg_vs_cube(-3 * ONE, ONE, ONE, 0, ONE, ONE), $urandom_range(0, 17));
    send_pair(seg_vs_cube(2 * ONE, ONE, ONE, 5 * ONE, ONE, ONE), 0);
    send_pair(seg_vs_cube(-3 * ONE, ONE, ONE, -1, ONE, ONE), 0);
    send_pair(seg_vs_cube(5 * ONE, ONE, ONE, -5 * ONE, ONE, ONE), $urandom_range(0, 17));
    send_pair(seg_vs_cube(-ONE, -ONE, ONE, 3 * ONE, 3 * ONE, ONE), 0);
    send_pair(seg_vs_cube(-ONE, -4 * ONE, ONE, 3 * ONE, 0, ONE), 0);
    send_pair(seg_vs_cube(ONE / 2, ONE / 2, ONE / 2, 3 * ONE / 2, 3 * ONE / 2, ONE), 0);
    send_pair(seg_vs_cube(-2 * ONE, -2 * ONE, -2 * ONE, 0, 0, 0), $urandom_range(0, 17));
    send_pair(pair_of(ONE, ONE, ONE, ONE, ONE, ONE,
                      2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0), 0);
    send_pair(pair_of(3 * ONE, ONE, ONE, 3 * ONE, ONE, ONE,
                      2 * ONE, 0, 0, 0, 2 * ONE, 2 * ONE), $urandom_range(0, 17));
    send_pair(pair_of(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                      CMIN, CMIN, CMIN, CMAX, CMAX, CMAX), 0);
    send_pair('0, 0);
    send_pair('1, $urandom_range(0, 17));
    send_pair(pair_of(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0, 0), 0);
    send_pair(pair_of(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                      CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 0);
    send_pair(pair_of(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                      CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), $urandom_range(0, 17));
    send_pair(pair_of(CMIN, 0, 0, CMAX, 0, 0, CMAX, 0, 0, CMAX, 0, 0), 0);
    n_directed = sent;
    drain_results();

    // Random: mostly well-formed pairs near the box, some noise and extremes
    burst = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2) drain_results();
      case ($urandom_range(0, 9))
        0, 1:    kind = K_NOISE;
        6:       kind = K_FLAT;
        7:       kind = K_POINT;
        8:       kind = K_TOUCH;
        9:       kind = K_EXTREME;
        default: kind = K_WELL;
      endcase
      send_pair(random_pair(kind), burst ? 0 : $urandom_range(0, 17));
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d segment/box pairs (%0d directed, %0d random), %0d results checked",
             sent, n_directed, sent - n_directed, checked);
    $display("%0d hits, %0d misses over points, flat axes, face/edge touches and extremes",
             hits, checked - hits);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/sbst_pkg.sv
rtl/core/segment_box_slab_test.sv
dv/segment_box_slab_test_chk.sv
dv/segment_box_slab_test_tb.sv
